@@ rtl/tfs_pkg.sv @@
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and constants of the transfer function sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tfs_pkg;

  localparam int unsigned IsoW  = 16;  // control point iso width
  localparam int unsigned QW    = 17;  // clamped sample iso quotient
  localparam int unsigned NumW  = 48;  // divider numerator width
  localparam int unsigned DenW  = 34;  // divider denominator width
  localparam int unsigned CntW  = 6;   // divider step counter width
  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    OP_COLOUR = 2'd0,
    OP_ALPHA  = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_RANGE_LOW    = 2'd0,
    REG_RANGE_HIGH   = 2'd1,
    REG_SAMPLE_COUNT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVS,
    S_SEL,
    S_PREP,
    S_LERP0,
    S_LERP
  } state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } tbl_stat_t;

  // v + d, saturated to a byte
  function automatic logic [ByteW-1:0] lerp_sat(input logic [ByteW-1:0] v,
                                                 input logic signed [NumW-1:0] d);
    logic signed [NumW:0] s;
    s = $signed({{(NumW+1-ByteW){1'b0}}, v}) + $signed({d[NumW-1], d});
    if (s < 0) begin
      return '0;
    end else if (s > 255) begin
      return '1;
    end else begin
      return s[ByteW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/transfer_function_sampler_top.sv @@
// ----------------------------------------------------------------------------
// transfer_function_sampler_top
// Two sorted control point tables; samples RGBA by linear interpolation.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o   | opcode, point_*, sample_index
//  out     | out_valid_o / out_stall_i | out_red/green/blue/alpha, status
//  cfg     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
//  Insert items and rejected samples are answered in the cycle after
//  acceptance. A sample is set by two passes of the 48-step serial
//  dividers (iso quotient, then the four interpolation weights in
//  parallel); a sample outside all points skips the second pass.
//  One item is in flight at a time; in_stall_o is high while busy or while
//  a result waits. Reset empties both tables and loads default ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module transfer_function_sampler_top #(
  parameter int unsigned COLOUR_DEPTH = 16,
  parameter int unsigned ALPHA_DEPTH  = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire logic [1:0]   opcode_i,
  input  wire logic signed [15:0] point_iso_i,
  input  wire logic [7:0]   point_red_i,
  input  wire logic [7:0]   point_green_i,
  input  wire logic [7:0]   point_blue_i,
  input  wire logic [7:0]   point_alpha_i,
  input  wire logic [15:0]  sample_index_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [7:0]        out_red_o,
  output logic [7:0]        out_green_o,
  output logic [7:0]        out_blue_o,
  output logic [7:0]        out_alpha_o,
  output logic [1:0]        status_o
);
  import tfs_pkg::*;

  state_e state_q, state_d;

  logic signed [IsoW-1:0] range_low_q, range_high_q;
  logic [IsoW-1:0]        sample_count_q, cnt;

  logic in_acc, out_acc;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic [1:0] status_q;
  logic       out_valid_q;

  tbl_stat_t c_stat, a_stat;
  logic signed [IsoW-1:0] c_first_iso, c_last_iso, c_lo_iso, c_hi_iso;
  logic signed [IsoW-1:0] a_first_iso, a_last_iso, a_lo_iso, a_hi_iso;
  logic [23:0] c_first_val, c_last_val, c_lo_val, c_hi_val;
  logic [7:0]  a_first_val, a_last_val, a_lo_val, a_hi_val;
  logic        c_nx, a_nx;

  logic signed [32:0] p0_q;
  logic signed [33:0] p1_q;
  logic signed [16:0] diff;
  logic signed [QW-1:0] q17_q;
  logic [IsoW-1:0]      rem_q;
  logic                 rnz_q;

  logic signed [IsoW-1:0] lowest, highest;
  logic signed [QW-1:0]   lo_x, hi_x;
  logic below_q, above_q;
  logic signed [IsoW-1:0] cl_iso_q, ch_iso_q, al_iso_q, ah_iso_q;
  logic [23:0] cl_val_q, ch_val_q;
  logic [7:0]  al_val_q, ah_val_q;
  logic        cnx_q, anx_q;

  logic signed [33:0] tc_q, ta_q;
  logic [DenW-1:0]    dc_q, da_q;
  logic               zc_q, za_q;
  logic signed [16:0] dqc, dqa, spc, spa;
  logic signed [QW-1:0] qc_off, qa_off;
  logic [IsoW-1:0]      dspan_c, dspan_a;

  logic                   start0, start1;
  logic signed [NumW-1:0] num [4];
  logic [DenW-1:0]        den [4];
  logic                   done [4];
  logic signed [NumW-1:0] quo [4];
  logic [DenW-1:0]        rem [4];
  logic signed [NumW-1:0] q48;
  logic signed [NumW-1:0] pc, pg, pb, pa;

  assign cnt     = (sample_count_q == '0) ? IsoW'(1) : sample_count_q;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_alpha_o = alpha_q;
  assign status_o    = status_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q    <= '0;
      range_high_q   <= 16'sh7fff;
      sample_count_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RANGE_LOW:    range_low_q    <= $signed(cfg_wdata_i);
        REG_RANGE_HIGH:   range_high_q   <= $signed(cfg_wdata_i);
        REG_SAMPLE_COUNT: sample_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tfs_table #(.DEPTH(COLOUR_DEPTH), .VW(24)) u_colour (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ins_i       (in_acc && (opcode_i == OP_COLOUR)),
    .new_iso_i   (point_iso_i),
    .new_val_i   ({point_red_i, point_green_i, point_blue_i}),
    .q_i         (q17_q),
    .rnz_i       (rnz_q),
    .stat_o      (c_stat),
    .first_iso_o (c_first_iso),
    .first_val_o (c_first_val),
    .last_iso_o  (c_last_iso),
    .last_val_o  (c_last_val),
    .lo_iso_o    (c_lo_iso),
    .lo_val_o    (c_lo_val),
    .hi_iso_o    (c_hi_iso),
    .hi_val_o    (c_hi_val),
    .has_next_o  (c_nx)
  );

  tfs_table #(.DEPTH(ALPHA_DEPTH), .VW(8)) u_alpha (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ins_i       (in_acc && (opcode_i == OP_ALPHA)),
    .new_iso_i   (point_iso_i),
    .new_val_i   (point_alpha_i),
    .q_i         (q17_q),
    .rnz_i       (rnz_q),
    .stat_o      (a_stat),
    .first_iso_o (a_first_iso),
    .first_val_o (a_first_val),
    .last_iso_o  (a_last_iso),
    .last_val_o  (a_last_val),
    .lo_iso_o    (a_lo_iso),
    .lo_val_o    (a_lo_val),
    .hi_iso_o    (a_hi_iso),
    .hi_val_o    (a_hi_val),
    .has_next_o  (a_nx)
  );

  // divider operands
  assign start0 = (state_q == S_MUL) || (state_q == S_LERP0);
  assign start1 = (state_q == S_LERP0);

  assign dqc = $signed({1'b0, ch_val_q[23:16]}) - $signed({1'b0, cl_val_q[23:16]});
  assign dqa = $signed({1'b0, ch_val_q[15:8]}) - $signed({1'b0, cl_val_q[15:8]});
  assign spc = $signed({1'b0, ch_val_q[7:0]}) - $signed({1'b0, cl_val_q[7:0]});
  assign spa = $signed({1'b0, ah_val_q}) - $signed({1'b0, al_val_q});

  assign pc = tc_q * dqc;
  assign pg = tc_q * dqa;
  assign pb = tc_q * spc;
  assign pa = ta_q * spa;

  assign num[0] = (state_q == S_MUL) ? NumW'(p0_q) + NumW'(p1_q) : (zc_q ? '0 : pc);
  assign den[0] = (state_q == S_MUL) ? DenW'(cnt) : (zc_q ? DenW'(1) : dc_q);
  assign num[1] = zc_q ? '0 : pg;
  assign den[1] = zc_q ? DenW'(1) : dc_q;
  assign num[2] = zc_q ? '0 : pb;
  assign den[2] = zc_q ? DenW'(1) : dc_q;
  assign num[3] = za_q ? '0 : pa;
  assign den[3] = za_q ? DenW'(1) : da_q;

  for (genvar i = 0; i < 4; i++) begin : g_div
    tfs_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i ((i == 0) ? start0 : start1),
      .num_i   (num[i]),
      .den_i   (den[i]),
      .done_o  (done[i]),
      .quo_o   (quo[i]),
      .rem_o   (rem[i])
    );
  end

  // overall bounds; both tables are filled whenever a sample runs
  assign lowest  = (c_first_iso < a_first_iso) ? c_first_iso : a_first_iso;
  assign highest = (c_last_iso > a_last_iso) ? c_last_iso : a_last_iso;
  assign lo_x    = $signed({lowest[IsoW-1], lowest});
  assign hi_x    = $signed({highest[IsoW-1], highest});
  assign diff    = $signed({range_high_q[15], range_high_q})
                 - $signed({range_low_q[15], range_low_q});
  assign q48     = quo[0];

  // sample offset from the segment start, and segment widths
  assign qc_off  = q17_q - QW'(cl_iso_q);
  assign qa_off  = q17_q - QW'(al_iso_q);
  assign dspan_c = ch_iso_q - cl_iso_q;
  assign dspan_a = ah_iso_q - al_iso_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (opcode_i == OP_SAMPLE) && !c_stat.empty && !a_stat.empty) begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_DIVS;
      S_DIVS:  if (done[0]) state_d = S_SEL;
      S_SEL:   state_d = S_PREP;
      S_PREP:  state_d = (below_q || above_q) ? S_IDLE : S_LERP0;
      S_LERP0: state_d = S_LERP;
      S_LERP:  if (done[0]) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && !((opcode_i == OP_SAMPLE) && !c_stat.empty
                             && !a_stat.empty)) begin
      out_valid_q <= 1'b1;
    end else if ((state_q == S_PREP && (below_q || above_q))
                 || (state_q == S_LERP && done[0])) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      alpha_q  <= '0;
      status_q <= STAT_OK;
      case (opcode_i)
        OP_COLOUR: if (c_stat.full) status_q <= STAT_FULL;
        OP_ALPHA:  if (a_stat.full) status_q <= STAT_FULL;
        OP_SAMPLE: if (c_stat.empty || a_stat.empty) status_q <= STAT_EMPTY;
        default: ;
      endcase
      p0_q <= range_low_q * $signed({1'b0, cnt});
      p1_q <= $signed({1'b0, sample_index_i}) * diff;
    end

    if (state_q == S_DIVS && done[0]) begin
      if (q48 > 65535) begin
        q17_q <= 17'sh0ffff;
      end else if (q48 < -65536) begin
        q17_q <= 17'sh10000;
      end else begin
        q17_q <= q48[QW-1:0];
      end
      rem_q <= rem[0][IsoW-1:0];
      rnz_q <= (rem[0] != '0);
    end

    if (state_q == S_SEL) begin
      below_q  <= !((q17_q > lo_x) || ((q17_q == lo_x) && rnz_q));
      above_q  <= (q17_q >= hi_x);
      cl_iso_q <= c_lo_iso;
      ch_iso_q <= c_hi_iso;
      cl_val_q <= c_lo_val;
      ch_val_q <= c_hi_val;
      cnx_q    <= c_nx;
      al_iso_q <= a_lo_iso;
      ah_iso_q <= a_hi_iso;
      al_val_q <= a_lo_val;
      ah_val_q <= a_hi_val;
      anx_q    <= a_nx;
    end

    if (state_q == S_PREP) begin
      if (below_q) begin
        {red_q, green_q, blue_q} <= c_first_val;
        alpha_q <= a_first_val;
      end else if (above_q) begin
        {red_q, green_q, blue_q} <= c_last_val;
        alpha_q <= a_last_val;
      end
      tc_q <= qc_off * $signed({1'b0, cnt}) + $signed({18'b0, rem_q});
      ta_q <= qa_off * $signed({1'b0, cnt}) + $signed({18'b0, rem_q});
      dc_q <= cnt * dspan_c;
      da_q <= cnt * dspan_a;
      zc_q <= !cnx_q || (ch_iso_q == cl_iso_q);
      za_q <= !anx_q || (ah_iso_q == al_iso_q);
    end

    if (state_q == S_LERP && done[0]) begin
      red_q   <= lerp_sat(cl_val_q[23:16], quo[0]);
      green_q <= lerp_sat(cl_val_q[15:8], quo[1]);
      blue_q  <= lerp_sat(cl_val_q[7:0], quo[2]);
      alpha_q <= lerp_sat(al_val_q, quo[3]);
    end
  end

endmodule

`default_nettype wire

@@ rtl/tfs_cell.sv @@
// ----------------------------------------------------------------------------
// tfs_cell
// One control point: sorted insert shifts from the left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_cell #(
  parameter int unsigned VW = 8
) (
  input  wire                              clk_i,
  input  wire                              ins_i,
  input  wire                              valid_i,
  input  wire logic signed [tfs_pkg::IsoW-1:0] new_iso_i,
  input  wire logic [VW-1:0]               new_val_i,
  input  wire logic signed [tfs_pkg::IsoW-1:0] left_iso_i,
  input  wire logic [VW-1:0]               left_val_i,
  input  wire                              left_keep_i,
  input  wire logic signed [tfs_pkg::QW-1:0] q_i,
  input  wire                              rnz_i,
  output logic signed [tfs_pkg::IsoW-1:0]  iso_o,
  output logic [VW-1:0]                    val_o,
  output logic                             keep_o,
  output logic                             gt_o
);
  import tfs_pkg::*;

  logic signed [IsoW-1:0] iso_q;
  logic [VW-1:0]          val_q;
  logic signed [QW-1:0]   iso_x;

  assign keep_o = valid_i && (iso_q <= new_iso_i);
  assign iso_x  = $signed({iso_q[IsoW-1], iso_q});
  // sample lies strictly above this point
  assign gt_o   = (q_i > iso_x) || ((q_i == iso_x) && rnz_i);
  assign iso_o  = iso_q;
  assign val_o  = val_q;

  always_ff @(posedge clk_i) begin
    if (ins_i && !keep_o) begin
      if (left_keep_i) begin
        iso_q <= new_iso_i;
        val_q <= new_val_i;
      end else begin
        iso_q <= left_iso_i;
        val_q <= left_val_i;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tfs_table.sv @@
// ----------------------------------------------------------------------------
// tfs_table
// Sorted row of control point cells with fill count and segment pick.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned VW    = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  ins_i,
  input  wire logic signed [tfs_pkg::IsoW-1:0] new_iso_i,
  input  wire logic [VW-1:0]                   new_val_i,
  input  wire logic signed [tfs_pkg::QW-1:0]   q_i,
  input  wire                                  rnz_i,
  output tfs_pkg::tbl_stat_t                   stat_o,
  output logic signed [tfs_pkg::IsoW-1:0]      first_iso_o,
  output logic [VW-1:0]                        first_val_o,
  output logic signed [tfs_pkg::IsoW-1:0]      last_iso_o,
  output logic [VW-1:0]                        last_val_o,
  output logic signed [tfs_pkg::IsoW-1:0]      lo_iso_o,
  output logic [VW-1:0]                        lo_val_o,
  output logic signed [tfs_pkg::IsoW-1:0]      hi_iso_o,
  output logic [VW-1:0]                        hi_val_o,
  output logic                                 has_next_o
);
  import tfs_pkg::*;

  localparam int unsigned UW = $clog2(DEPTH + 1);

  logic [UW-1:0]          used_q;
  logic                   do_ins;
  logic signed [IsoW-1:0] iso   [DEPTH];
  logic [VW-1:0]          val   [DEPTH];
  logic                   keep  [DEPTH];
  logic                   gt    [DEPTH];
  logic                   vld   [DEPTH];
  logic                   vnx   [DEPTH];
  logic                   gnx   [DEPTH];
  logic signed [IsoW-1:0] isonx [DEPTH];
  logic [VW-1:0]          valnx [DEPTH];
  logic                   sel   [DEPTH];

  assign stat_o.full  = (used_q == UW'(DEPTH));
  assign stat_o.empty = (used_q == '0);
  assign do_ins       = ins_i && !stat_o.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (do_ins) begin
      used_q <= used_q + UW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [IsoW-1:0] l_iso;
    logic [VW-1:0]          l_val;
    logic                   l_keep;

    assign vld[i] = (UW'(i) < used_q);

    if (i == 0) begin : g_head
      assign l_iso  = new_iso_i;
      assign l_val  = new_val_i;
      assign l_keep = 1'b1;
      assign sel[i] = vld[i] && !(vnx[i] && gnx[i]);
    end else begin : g_body
      assign l_iso  = iso[i-1];
      assign l_val  = val[i-1];
      assign l_keep = keep[i-1];
      assign sel[i] = vld[i] && gt[i] && !(vnx[i] && gnx[i]);
    end

    if (i == DEPTH - 1) begin : g_tail
      assign vnx[i]   = 1'b0;
      assign gnx[i]   = 1'b0;
      assign isonx[i] = '0;
      assign valnx[i] = '0;
    end else begin : g_mid
      assign vnx[i]   = vld[i+1];
      assign gnx[i]   = gt[i+1];
      assign isonx[i] = iso[i+1];
      assign valnx[i] = val[i+1];
    end

    tfs_cell #(.VW(VW)) u_cell (
      .clk_i       (clk_i),
      .ins_i       (do_ins),
      .valid_i     (vld[i]),
      .new_iso_i   (new_iso_i),
      .new_val_i   (new_val_i),
      .left_iso_i  (l_iso),
      .left_val_i  (l_val),
      .left_keep_i (l_keep),
      .q_i         (q_i),
      .rnz_i       (rnz_i),
      .iso_o       (iso[i]),
      .val_o       (val[i]),
      .keep_o      (keep[i]),
      .gt_o        (gt[i])
    );
  end

  assign first_iso_o = iso[0];
  assign first_val_o = val[0];

  // one-hot picks: segment start and end, last filled cell
  always_comb begin
    lo_iso_o   = '0;
    lo_val_o   = '0;
    hi_iso_o   = '0;
    hi_val_o   = '0;
    has_next_o = 1'b0;
    last_iso_o = '0;
    last_val_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        lo_iso_o   = lo_iso_o | iso[i];
        lo_val_o   = lo_val_o | val[i];
        hi_iso_o   = hi_iso_o | isonx[i];
        hi_val_o   = hi_val_o | valnx[i];
        has_next_o = has_next_o | vnx[i];
      end
      if (vld[i] && !vnx[i]) begin
        last_iso_o = last_iso_o | iso[i];
        last_val_o = last_val_o | val[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tfs_div.sv @@
// ----------------------------------------------------------------------------
// tfs_div
// Bit-serial floor divider: signed numerator, positive denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_div (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire logic signed [tfs_pkg::NumW-1:0] num_i,
  input  wire logic [tfs_pkg::DenW-1:0]        den_i,
  output logic                                 done_o,
  output logic signed [tfs_pkg::NumW-1:0]      quo_o,
  output logic [tfs_pkg::DenW-1:0]             rem_o
);
  import tfs_pkg::*;

  logic            busy_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] den_q, acc_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   trial;
  logic            fits, rnz;

  assign trial = {acc_q, quo_q[NumW-1]};
  assign fits  = (trial >= {1'b0, den_q});
  assign rnz   = (acc_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NumW-1];
      quo_q <= num_i[NumW-1] ? -num_i : num_i;
      acc_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  // round toward minus infinity for negative numerators
  always_comb begin
    if (neg_q && rnz) begin
      quo_o = $signed(~quo_q);
      rem_o = den_q - acc_q;
    end else if (neg_q) begin
      quo_o = $signed(-quo_q);
      rem_o = acc_q;
    end else begin
      quo_o = $signed(quo_q);
      rem_o = acc_q;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire
